### hw/rtl/szl_pkg.sv
// szl_pkg: shared constants, codes and types of the sample zone lookup
// used by every module of the block except szl_ram; no dependencies
`default_nettype none

package szl_pkg;

    localparam int PRESET_DEPTH = 256;
    localparam int BAG_DEPTH    = 1024;
    localparam int GEN_DEPTH    = 4096;
    localparam int INST_DEPTH   = 256;
    localparam int SAMPLE_DEPTH = 1024;

    localparam int PRESET_AW = (PRESET_DEPTH > 1) ? $clog2(PRESET_DEPTH) : 1;
    localparam int BAG_AW    = (BAG_DEPTH > 1) ? $clog2(BAG_DEPTH) : 1;
    localparam int GEN_AW    = (GEN_DEPTH > 1) ? $clog2(GEN_DEPTH) : 1;
    localparam int INST_AW   = (INST_DEPTH > 1) ? $clog2(INST_DEPTH) : 1;
    localparam int SAMPLE_AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

    localparam int APB_AW = 5;

    localparam logic [15:0] GEN_INSTRUMENT  = 16'd41;
    localparam logic [15:0] GEN_KEY_RANGE   = 16'd43;
    localparam logic [15:0] GEN_VEL_RANGE   = 16'd44;
    localparam logic [15:0] GEN_ATTEN       = 16'd48;
    localparam logic [15:0] GEN_SAMPLE_ID   = 16'd53;
    localparam logic [15:0] GEN_SAMPLE_MODE = 16'd54;
    localparam logic [15:0] GEN_ROOT_KEY    = 16'd58;

    localparam logic [15:0] MODE_LOOP       = 16'd1;
    localparam logic [15:0] MODE_LOOP_REL   = 16'd3;
    localparam logic [15:0] ROOT_NONE       = 16'hFFFF;
    localparam logic [15:0] ROOT_DEFAULT    = 16'd60;
    localparam logic [7:0]  RANGE_MAX       = 8'd127;
    localparam logic [7:0]  PITCH_MASK      = 8'hFF;

    typedef enum logic [2:0] {
        OP_PRESET     = 3'd0,
        OP_PBAG       = 3'd1,
        OP_PGEN       = 3'd2,
        OP_INSTRUMENT = 3'd3,
        OP_IBAG       = 3'd4,
        OP_IGEN       = 3'd5,
        OP_PITCH      = 3'd6,
        OP_QUERY      = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        REG_PRESET_COUNT     = 3'd0,
        REG_PRESET_BAG_COUNT = 3'd1,
        REG_INST_COUNT       = 3'd2,
        REG_INST_BAG_COUNT   = 3'd3,
        REG_SAMPLE_COUNT     = 3'd4
    } t_reg_idx;

    typedef enum logic [4:0] {
        ST_IDLE, ST_P_RD, ST_P_CMP, ST_PE_RD, ST_PE_USE,
        ST_PB_RD, ST_PB_RD2, ST_PB_USE, ST_PG_RD, ST_PG_USE, ST_PZ_EVAL,
        ST_I_RD, ST_I_RD2, ST_I_USE,
        ST_IB_RD, ST_IB_RD2, ST_IB_USE, ST_IG_RD, ST_IG_USE, ST_IZ_EVAL,
        ST_S_RD, ST_S_USE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_START, CMD_MISS, CMD_HIT,
        CMD_P_RD, CMD_P_NEXT, CMD_P_HIT, CMD_PE_RD, CMD_PE_USE,
        CMD_PB_RD, CMD_PB_RD2, CMD_PB_USE, CMD_PG_RD, CMD_PG_USE, CMD_PZ_EVAL,
        CMD_B_NEXT, CMD_I_RD, CMD_I_RD2, CMD_I_USE,
        CMD_IB_RD, CMD_IB_RD2, CMD_IB_USE, CMD_IG_RD, CMD_IG_USE, CMD_IZ_EVAL,
        CMD_S_RD
    } t_cmd;

    typedef struct packed {
        logic out_valid;
        logic p_over;
        logic p_match;
        logic p_last;
        logic pb_over;
        logic pg_over;
        logic pz_take;
        logic ib_over;
        logic ig_over;
        logic iz_take;
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/sample_zone_lookup.sv
// sample_zone_lookup: top level, configuration registers and request handshake
// depends on szl_pkg, szl_ctrl, szl_dpath
// load request: written to its table when accepted; query: scans preset records, then preset
// zones, their generators and instrument zones, paced by the single read port of each table
// memory; one request at a time, result held in an output register
// reset: synchronous active low, clears sequencer, counts and result valid; tables keep data
`default_nettype none

module sample_zone_lookup (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [szl_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [2:0]                  i_opcode,
    input  wire logic [11:0]                 i_index,
    input  wire logic [15:0]                 i_first_word,
    input  wire logic [15:0]                 i_second_word,
    input  wire logic [15:0]                 i_third_word,
    input  wire logic [6:0]                  i_note,
    input  wire logic [6:0]                  i_velocity,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_found,
    output logic [9:0]                       o_sample_index,
    output logic signed [15:0]               o_root_key,
    output logic signed [17:0]               o_attenuation,
    output logic                             o_has_loop
);

    logic [8:0]  r_preset_count, r_inst_count;
    logic [10:0] r_preset_bag_count, r_inst_bag_count, r_sample_count;
    logic        cfg_we;
    szl_pkg::t_reg_idx reg_idx;
    szl_pkg::t_cmd     cmd;
    szl_pkg::t_status  status;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = szl_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset_count     <= '0;
            r_preset_bag_count <= '0;
            r_inst_count       <= '0;
            r_inst_bag_count   <= '0;
            r_sample_count     <= '0;
        end else if (cfg_we) begin
            case (reg_idx)
                szl_pkg::REG_PRESET_COUNT:     r_preset_count     <= pwdata[8:0];
                szl_pkg::REG_PRESET_BAG_COUNT: r_preset_bag_count <= pwdata[10:0];
                szl_pkg::REG_INST_COUNT:       r_inst_count       <= pwdata[8:0];
                szl_pkg::REG_INST_BAG_COUNT:   r_inst_bag_count   <= pwdata[10:0];
                szl_pkg::REG_SAMPLE_COUNT:     r_sample_count     <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            szl_pkg::REG_PRESET_COUNT:     prdata = 32'(r_preset_count);
            szl_pkg::REG_PRESET_BAG_COUNT: prdata = 32'(r_preset_bag_count);
            szl_pkg::REG_INST_COUNT:       prdata = 32'(r_inst_count);
            szl_pkg::REG_INST_BAG_COUNT:   prdata = 32'(r_inst_bag_count);
            szl_pkg::REG_SAMPLE_COUNT:     prdata = 32'(r_sample_count);
            default:                       prdata = '0;
        endcase
    end

    szl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_is_query (i_opcode == szl_pkg::OP_QUERY),
        .o_ready    (o_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    szl_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_opcode           (i_opcode),
        .i_index            (i_index),
        .i_first_word       (i_first_word),
        .i_second_word      (i_second_word),
        .i_third_word       (i_third_word),
        .i_note             (i_note),
        .i_velocity         (i_velocity),
        .i_preset_count     (r_preset_count),
        .i_preset_bag_count (r_preset_bag_count),
        .i_inst_count       (r_inst_count),
        .i_inst_bag_count   (r_inst_bag_count),
        .i_sample_count     (r_sample_count),
        .i_out_ready        (i_ready),
        .o_out_valid        (o_valid),
        .o_found            (o_found),
        .o_sample_index     (o_sample_index),
        .o_root_key         (o_root_key),
        .o_attenuation      (o_attenuation),
        .o_has_loop         (o_has_loop)
    );

endmodule

`default_nettype wire

### hw/rtl/szl_ram.sv
// szl_ram: generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module szl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/szl_ctrl.sv
// szl_ctrl: sequencer of the zone lookup, issues one command per cycle
// depends on szl_pkg
`default_nettype none

module szl_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_is_query,
    output logic                 o_ready,
    input  wire szl_pkg::t_status i_status,
    output szl_pkg::t_cmd        o_cmd
);

    szl_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= szl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = szl_pkg::CMD_NONE;
        o_ready = 1'b0;
        case (r_state)
            szl_pkg::ST_IDLE: begin
                o_ready = !i_status.out_valid || !i_is_query;
                if (i_valid && o_ready) begin
                    if (i_is_query) begin
                        o_cmd   = szl_pkg::CMD_START;
                        n_state = szl_pkg::ST_P_RD;
                    end else begin
                        o_cmd = szl_pkg::CMD_LOAD;
                    end
                end
            end
            szl_pkg::ST_P_RD: begin
                if (i_status.p_over) begin
                    o_cmd   = szl_pkg::CMD_MISS;
                    n_state = szl_pkg::ST_IDLE;
                end else begin
                    o_cmd   = szl_pkg::CMD_P_RD;
                    n_state = szl_pkg::ST_P_CMP;
                end
            end
            szl_pkg::ST_P_CMP: begin
                if (i_status.p_match && i_status.p_last) begin
                    o_cmd   = szl_pkg::CMD_MISS;
                    n_state = szl_pkg::ST_IDLE;
                end else if (i_status.p_match) begin
                    o_cmd   = szl_pkg::CMD_P_HIT;
                    n_state = szl_pkg::ST_PE_RD;
                end else begin
                    o_cmd   = szl_pkg::CMD_P_NEXT;
                    n_state = szl_pkg::ST_P_RD;
                end
            end
            szl_pkg::ST_PE_RD: begin
                o_cmd   = szl_pkg::CMD_PE_RD;
                n_state = szl_pkg::ST_PE_USE;
            end
            szl_pkg::ST_PE_USE: begin
                o_cmd   = szl_pkg::CMD_PE_USE;
                n_state = szl_pkg::ST_PB_RD;
            end
            szl_pkg::ST_PB_RD: begin
                if (i_status.pb_over) begin
                    o_cmd   = szl_pkg::CMD_MISS;
                    n_state = szl_pkg::ST_IDLE;
                end else begin
                    o_cmd   = szl_pkg::CMD_PB_RD;
                    n_state = szl_pkg::ST_PB_RD2;
                end
            end
            szl_pkg::ST_PB_RD2: begin
                o_cmd   = szl_pkg::CMD_PB_RD2;
                n_state = szl_pkg::ST_PB_USE;
            end
            szl_pkg::ST_PB_USE: begin
                o_cmd   = szl_pkg::CMD_PB_USE;
                n_state = szl_pkg::ST_PG_RD;
            end
            szl_pkg::ST_PG_RD: begin
                if (i_status.pg_over) begin
                    n_state = szl_pkg::ST_PZ_EVAL;
                end else begin
                    o_cmd   = szl_pkg::CMD_PG_RD;
                    n_state = szl_pkg::ST_PG_USE;
                end
            end
            szl_pkg::ST_PG_USE: begin
                o_cmd   = szl_pkg::CMD_PG_USE;
                n_state = szl_pkg::ST_PG_RD;
            end
            szl_pkg::ST_PZ_EVAL: begin
                o_cmd   = szl_pkg::CMD_PZ_EVAL;
                n_state = i_status.pz_take ? szl_pkg::ST_I_RD : szl_pkg::ST_PB_RD;
            end
            szl_pkg::ST_I_RD: begin
                o_cmd   = szl_pkg::CMD_I_RD;
                n_state = szl_pkg::ST_I_RD2;
            end
            szl_pkg::ST_I_RD2: begin
                o_cmd   = szl_pkg::CMD_I_RD2;
                n_state = szl_pkg::ST_I_USE;
            end
            szl_pkg::ST_I_USE: begin
                o_cmd   = szl_pkg::CMD_I_USE;
                n_state = szl_pkg::ST_IB_RD;
            end
            szl_pkg::ST_IB_RD: begin
                if (i_status.ib_over) begin
                    o_cmd   = szl_pkg::CMD_B_NEXT;
                    n_state = szl_pkg::ST_PB_RD;
                end else begin
                    o_cmd   = szl_pkg::CMD_IB_RD;
                    n_state = szl_pkg::ST_IB_RD2;
                end
            end
            szl_pkg::ST_IB_RD2: begin
                o_cmd   = szl_pkg::CMD_IB_RD2;
                n_state = szl_pkg::ST_IB_USE;
            end
            szl_pkg::ST_IB_USE: begin
                o_cmd   = szl_pkg::CMD_IB_USE;
                n_state = szl_pkg::ST_IG_RD;
            end
            szl_pkg::ST_IG_RD: begin
                if (i_status.ig_over) begin
                    n_state = szl_pkg::ST_IZ_EVAL;
                end else begin
                    o_cmd   = szl_pkg::CMD_IG_RD;
                    n_state = szl_pkg::ST_IG_USE;
                end
            end
            szl_pkg::ST_IG_USE: begin
                o_cmd   = szl_pkg::CMD_IG_USE;
                n_state = szl_pkg::ST_IG_RD;
            end
            szl_pkg::ST_IZ_EVAL: begin
                o_cmd   = szl_pkg::CMD_IZ_EVAL;
                n_state = i_status.iz_take ? szl_pkg::ST_S_RD : szl_pkg::ST_IB_RD;
            end
            szl_pkg::ST_S_RD: begin
                o_cmd   = szl_pkg::CMD_S_RD;
                n_state = szl_pkg::ST_S_USE;
            end
            szl_pkg::ST_S_USE: begin
                o_cmd   = szl_pkg::CMD_HIT;
                n_state = szl_pkg::ST_IDLE;
            end
            default: begin
                n_state = szl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/szl_dpath.sv
// szl_dpath: table memories, walk registers and result register of the lookup
// depends on szl_pkg and szl_ram
`default_nettype none

module szl_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire szl_pkg::t_cmd      i_cmd,
    output szl_pkg::t_status        o_status,
    input  wire logic [2:0]         i_opcode,
    input  wire logic [11:0]        i_index,
    input  wire logic [15:0]        i_first_word,
    input  wire logic [15:0]        i_second_word,
    input  wire logic [15:0]        i_third_word,
    input  wire logic [6:0]         i_note,
    input  wire logic [6:0]         i_velocity,
    input  wire logic [8:0]         i_preset_count,
    input  wire logic [10:0]        i_preset_bag_count,
    input  wire logic [8:0]         i_inst_count,
    input  wire logic [10:0]        i_inst_bag_count,
    input  wire logic [10:0]        i_sample_count,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_found,
    output logic [9:0]              o_sample_index,
    output logic signed [15:0]      o_root_key,
    output logic signed [17:0]      o_attenuation,
    output logic                    o_has_loop
);

    logic [8:0]  pc, ic;
    logic [10:0] pbc, ibc, sc;

    logic [47:0] prs_rdata;
    logic [15:0] pbag_rdata, inst_rdata, ibag_rdata;
    logic [31:0] pgen_rdata, igen_rdata;
    logic [7:0]  pitch_rdata;

    logic we_prs, we_pbag, we_pgen, we_inst, we_ibag, we_igen, we_pitch;

    logic [szl_pkg::PRESET_AW-1:0] prs_raddr;
    logic [szl_pkg::BAG_AW-1:0]    pbag_raddr, ibag_raddr;
    logic [szl_pkg::INST_AW-1:0]   inst_raddr;

    logic [15:0] r_bank, r_prog;
    logic [6:0]  r_note, r_vel;
    logic [8:0]  r_i;
    logic [15:0] r_p_first, r_p_end, r_b, r_g, r_g_end;
    logic [15:0] r_i_first, r_i_end, r_ib;
    logic [7:0]  r_gk_lo, r_gk_hi, r_gv_lo, r_gv_hi;
    logic [7:0]  r_ik_lo, r_ik_hi, r_iv_lo, r_iv_hi;
    logic [7:0]  r_klo, r_khi, r_vlo, r_vhi;
    logic signed [15:0] r_g_att, r_i_att, r_z_att;
    logic signed [16:0] r_p_att;
    logic [15:0] r_inst, r_smp, r_mode, r_root;
    logic        r_inst_ok, r_smp_ok;

    logic [9:0]  i_inc;
    logic [16:0] b_inc, ib_inc, inst_inc;
    logic        key_ok, vel_ok, pz_global, iz_global;
    logic [15:0] pg_op, pg_amt, ig_op, ig_amt;

    assign pc  = (32'(i_preset_count) > szl_pkg::PRESET_DEPTH)
               ? 9'(szl_pkg::PRESET_DEPTH) : i_preset_count;
    assign ic  = (32'(i_inst_count) > szl_pkg::INST_DEPTH)
               ? 9'(szl_pkg::INST_DEPTH) : i_inst_count;
    assign pbc = (32'(i_preset_bag_count) > szl_pkg::BAG_DEPTH)
               ? 11'(szl_pkg::BAG_DEPTH) : i_preset_bag_count;
    assign ibc = (32'(i_inst_bag_count) > szl_pkg::BAG_DEPTH)
               ? 11'(szl_pkg::BAG_DEPTH) : i_inst_bag_count;
    assign sc  = (32'(i_sample_count) > szl_pkg::SAMPLE_DEPTH)
               ? 11'(szl_pkg::SAMPLE_DEPTH) : i_sample_count;

    // load decode
    always_comb begin
        we_prs   = 1'b0;
        we_pbag  = 1'b0;
        we_pgen  = 1'b0;
        we_inst  = 1'b0;
        we_ibag  = 1'b0;
        we_igen  = 1'b0;
        we_pitch = 1'b0;
        if (i_cmd == szl_pkg::CMD_LOAD) begin
            case (szl_pkg::t_opcode'(i_opcode))
                szl_pkg::OP_PRESET:     we_prs   = 32'(i_index) < szl_pkg::PRESET_DEPTH;
                szl_pkg::OP_PBAG:       we_pbag  = 32'(i_index) < szl_pkg::BAG_DEPTH;
                szl_pkg::OP_PGEN:       we_pgen  = 32'(i_index) < szl_pkg::GEN_DEPTH;
                szl_pkg::OP_INSTRUMENT: we_inst  = 32'(i_index) < szl_pkg::INST_DEPTH;
                szl_pkg::OP_IBAG:       we_ibag  = 32'(i_index) < szl_pkg::BAG_DEPTH;
                szl_pkg::OP_IGEN:       we_igen  = 32'(i_index) < szl_pkg::GEN_DEPTH;
                szl_pkg::OP_PITCH:      we_pitch = 32'(i_index) < szl_pkg::SAMPLE_DEPTH;
                default: begin
                end
            endcase
        end
    end

    assign i_inc    = {1'b0, r_i} + 10'd1;
    assign b_inc    = {1'b0, r_b} + 17'd1;
    assign ib_inc   = {1'b0, r_ib} + 17'd1;
    assign inst_inc = {1'b0, r_inst} + 17'd1;

    assign prs_raddr  = (i_cmd == szl_pkg::CMD_PE_RD) ? i_inc[szl_pkg::PRESET_AW-1:0]
                                                      : r_i[szl_pkg::PRESET_AW-1:0];
    assign pbag_raddr = (i_cmd == szl_pkg::CMD_PB_RD2) ? b_inc[szl_pkg::BAG_AW-1:0]
                                                       : r_b[szl_pkg::BAG_AW-1:0];
    assign ibag_raddr = (i_cmd == szl_pkg::CMD_IB_RD2) ? ib_inc[szl_pkg::BAG_AW-1:0]
                                                       : r_ib[szl_pkg::BAG_AW-1:0];
    assign inst_raddr = (i_cmd == szl_pkg::CMD_I_RD2) ? inst_inc[szl_pkg::INST_AW-1:0]
                                                      : r_inst[szl_pkg::INST_AW-1:0];

    szl_ram #(.WIDTH(48), .DEPTH(szl_pkg::PRESET_DEPTH)) u_prs (
        .i_clk(i_clk), .i_we(we_prs), .i_waddr(szl_pkg::PRESET_AW'(i_index)),
        .i_wdata({i_first_word, i_second_word, i_third_word}),
        .i_raddr(prs_raddr), .o_rdata(prs_rdata));

    szl_ram #(.WIDTH(16), .DEPTH(szl_pkg::BAG_DEPTH)) u_pbag (
        .i_clk(i_clk), .i_we(we_pbag), .i_waddr(szl_pkg::BAG_AW'(i_index)),
        .i_wdata(i_first_word), .i_raddr(pbag_raddr), .o_rdata(pbag_rdata));

    szl_ram #(.WIDTH(32), .DEPTH(szl_pkg::GEN_DEPTH)) u_pgen (
        .i_clk(i_clk), .i_we(we_pgen), .i_waddr(szl_pkg::GEN_AW'(i_index)),
        .i_wdata({i_first_word, i_second_word}),
        .i_raddr(r_g[szl_pkg::GEN_AW-1:0]), .o_rdata(pgen_rdata));

    szl_ram #(.WIDTH(16), .DEPTH(szl_pkg::INST_DEPTH)) u_inst (
        .i_clk(i_clk), .i_we(we_inst), .i_waddr(szl_pkg::INST_AW'(i_index)),
        .i_wdata(i_first_word), .i_raddr(inst_raddr), .o_rdata(inst_rdata));

    szl_ram #(.WIDTH(16), .DEPTH(szl_pkg::BAG_DEPTH)) u_ibag (
        .i_clk(i_clk), .i_we(we_ibag), .i_waddr(szl_pkg::BAG_AW'(i_index)),
        .i_wdata(i_first_word), .i_raddr(ibag_raddr), .o_rdata(ibag_rdata));

    szl_ram #(.WIDTH(32), .DEPTH(szl_pkg::GEN_DEPTH)) u_igen (
        .i_clk(i_clk), .i_we(we_igen), .i_waddr(szl_pkg::GEN_AW'(i_index)),
        .i_wdata({i_first_word, i_second_word}),
        .i_raddr(r_g[szl_pkg::GEN_AW-1:0]), .o_rdata(igen_rdata));

    szl_ram #(.WIDTH(8), .DEPTH(szl_pkg::SAMPLE_DEPTH)) u_pitch (
        .i_clk(i_clk), .i_we(we_pitch), .i_waddr(szl_pkg::SAMPLE_AW'(i_index)),
        .i_wdata(i_first_word[7:0] & szl_pkg::PITCH_MASK),
        .i_raddr(r_smp[szl_pkg::SAMPLE_AW-1:0]), .o_rdata(pitch_rdata));

    assign pg_op  = pgen_rdata[31:16];
    assign pg_amt = pgen_rdata[15:0];
    assign ig_op  = igen_rdata[31:16];
    assign ig_amt = igen_rdata[15:0];

    assign key_ok    = ({1'b0, r_note} >= r_klo) && ({1'b0, r_note} <= r_khi);
    assign vel_ok    = ({1'b0, r_vel} >= r_vlo) && ({1'b0, r_vel} <= r_vhi);
    assign pz_global = !r_inst_ok && (r_b == r_p_first);
    assign iz_global = !r_smp_ok && (r_ib == r_i_first);

    always_comb begin
        o_status.out_valid = o_out_valid;
        o_status.p_over    = r_i >= pc;
        o_status.p_match   = (prs_rdata[47:32] == r_bank) && (prs_rdata[31:16] == r_prog);
        o_status.p_last    = i_inc >= {1'b0, pc};
        o_status.pb_over   = !((r_b < r_p_end) && (b_inc < 17'(pbc)));
        o_status.pg_over   = !((r_g < r_g_end) && (17'(r_g) < 17'(szl_pkg::GEN_DEPTH)));
        o_status.pz_take   = !pz_global && key_ok && vel_ok && r_inst_ok
                           && (inst_inc < 17'(ic));
        o_status.ib_over   = !((r_ib < r_i_end) && (ib_inc < 17'(ibc)));
        o_status.ig_over   = o_status.pg_over;
        o_status.iz_take   = !iz_global && key_ok && vel_ok && r_smp_ok
                           && (r_smp < 16'(sc));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd == szl_pkg::CMD_MISS || i_cmd == szl_pkg::CMD_HIT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            szl_pkg::CMD_START: begin
                r_bank <= i_first_word;
                r_prog <= i_second_word;
                r_note <= i_note;
                r_vel  <= i_velocity;
                r_i    <= '0;
            end
            szl_pkg::CMD_P_NEXT: r_i <= i_inc[8:0];
            szl_pkg::CMD_P_HIT:  r_p_first <= prs_rdata[15:0];
            szl_pkg::CMD_PE_USE: begin
                r_p_end <= prs_rdata[15:0];
                r_b     <= r_p_first;
                r_gk_lo <= '0;
                r_gk_hi <= szl_pkg::RANGE_MAX;
                r_gv_lo <= '0;
                r_gv_hi <= szl_pkg::RANGE_MAX;
                r_g_att <= '0;
            end
            szl_pkg::CMD_PB_RD2: r_g <= pbag_rdata;
            szl_pkg::CMD_PB_USE: begin
                r_g_end   <= pbag_rdata;
                r_klo     <= r_gk_lo;
                r_khi     <= r_gk_hi;
                r_vlo     <= r_gv_lo;
                r_vhi     <= r_gv_hi;
                r_z_att   <= '0;
                r_inst    <= '0;
                r_inst_ok <= 1'b0;
            end
            szl_pkg::CMD_PG_USE: begin
                r_g <= r_g + 16'd1;
                if (pg_op == szl_pkg::GEN_KEY_RANGE) begin
                    r_klo <= pg_amt[7:0];
                    r_khi <= pg_amt[15:8];
                end
                if (pg_op == szl_pkg::GEN_VEL_RANGE) begin
                    r_vlo <= pg_amt[7:0];
                    r_vhi <= pg_amt[15:8];
                end
                if (pg_op == szl_pkg::GEN_INSTRUMENT) begin
                    r_inst    <= pg_amt;
                    r_inst_ok <= 1'b1;
                end
                if (pg_op == szl_pkg::GEN_ATTEN) begin
                    r_z_att <= pg_amt;
                end
            end
            szl_pkg::CMD_PZ_EVAL: begin
                if (pz_global) begin
                    r_gk_lo <= r_klo;
                    r_gk_hi <= r_khi;
                    r_gv_lo <= r_vlo;
                    r_gv_hi <= r_vhi;
                    r_g_att <= r_z_att;
                    r_b     <= b_inc[15:0];
                end else if (o_status.pz_take) begin
                    r_p_att <= 17'(r_g_att) + 17'(r_z_att);
                end else begin
                    r_b <= b_inc[15:0];
                end
            end
            szl_pkg::CMD_B_NEXT: r_b <= b_inc[15:0];
            szl_pkg::CMD_I_RD2:  r_i_first <= inst_rdata;
            szl_pkg::CMD_I_USE: begin
                r_i_end <= inst_rdata;
                r_ib    <= r_i_first;
                r_ik_lo <= '0;
                r_ik_hi <= szl_pkg::RANGE_MAX;
                r_iv_lo <= '0;
                r_iv_hi <= szl_pkg::RANGE_MAX;
                r_i_att <= '0;
            end
            szl_pkg::CMD_IB_RD2: r_g <= ibag_rdata;
            szl_pkg::CMD_IB_USE: begin
                r_g_end  <= ibag_rdata;
                r_klo    <= r_ik_lo;
                r_khi    <= r_ik_hi;
                r_vlo    <= r_iv_lo;
                r_vhi    <= r_iv_hi;
                r_z_att  <= '0;
                r_smp    <= '0;
                r_smp_ok <= 1'b0;
                r_mode   <= '0;
                r_root   <= szl_pkg::ROOT_NONE;
            end
            szl_pkg::CMD_IG_USE: begin
                r_g <= r_g + 16'd1;
                if (ig_op == szl_pkg::GEN_KEY_RANGE) begin
                    r_klo <= ig_amt[7:0];
                    r_khi <= ig_amt[15:8];
                end
                if (ig_op == szl_pkg::GEN_VEL_RANGE) begin
                    r_vlo <= ig_amt[7:0];
                    r_vhi <= ig_amt[15:8];
                end
                if (ig_op == szl_pkg::GEN_ATTEN) begin
                    r_z_att <= ig_amt;
                end
                if (ig_op == szl_pkg::GEN_SAMPLE_ID) begin
                    r_smp    <= ig_amt;
                    r_smp_ok <= 1'b1;
                end
                if (ig_op == szl_pkg::GEN_ROOT_KEY) begin
                    r_root <= ig_amt;
                end
                if (ig_op == szl_pkg::GEN_SAMPLE_MODE) begin
                    r_mode <= ig_amt;
                end
            end
            szl_pkg::CMD_IZ_EVAL: begin
                if (iz_global) begin
                    r_ik_lo <= r_klo;
                    r_ik_hi <= r_khi;
                    r_iv_lo <= r_vlo;
                    r_iv_hi <= r_vhi;
                    r_i_att <= r_z_att;
                    r_ib    <= ib_inc[15:0];
                end else if (!o_status.iz_take) begin
                    r_ib <= ib_inc[15:0];
                end
            end
            szl_pkg::CMD_MISS: begin
                o_found        <= 1'b0;
                o_sample_index <= '0;
                o_root_key     <= szl_pkg::ROOT_DEFAULT;
                o_attenuation  <= '0;
                o_has_loop     <= 1'b0;
            end
            szl_pkg::CMD_HIT: begin
                o_found        <= 1'b1;
                o_sample_index <= r_smp[9:0];
                o_root_key     <= (r_root != szl_pkg::ROOT_NONE) ? r_root
                                                                 : {8'd0, pitch_rdata};
                o_attenuation  <= 18'(r_p_att) + 18'(r_i_att) + 18'(r_z_att);
                o_has_loop     <= (r_mode == szl_pkg::MODE_LOOP)
                               || (r_mode == szl_pkg::MODE_LOOP_REL);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/szl_checker.sv
// szl_checker: port-level assertions of the lookup, bound to the top level
// depends on szl_pkg and sample_zone_lookup
`default_nettype none

module szl_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic [2:0]         i_opcode,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic               o_found,
    input wire logic [9:0]         o_sample_index,
    input wire logic signed [15:0] o_root_key,
    input wire logic signed [17:0] o_attenuation,
    input wire logic               o_has_loop
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_query_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_opcode == szl_pkg::OP_QUERY) |-> !o_valid)
        else $error("query taken while a result waits");

    a_query_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_opcode == szl_pkg::OP_QUERY) |=> !o_valid)
        else $error("result one cycle after query");

    a_miss_defaults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_sample_index == '0 && o_attenuation == '0
            && o_root_key == szl_pkg::ROOT_DEFAULT && !o_has_loop))
        else $error("not-found result carries data");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_found)
            && $stable(o_sample_index) && $stable(o_attenuation)))
        else $error("stalled result changed");

endmodule

bind sample_zone_lookup szl_checker u_szl_checker (.*);

`default_nettype wire
